// File: sv/sorted_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared property forms for the queue checks, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation and status codes, data width and the cell control group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DATA_BITS = 32;
   localparam int OP_BITS   = 2;
   localparam int STAT_BITS = 2;
   localparam int PRIO_IN_BITS = 8;

   typedef enum logic [OP_BITS-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2
   } op_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef logic signed [DATA_BITS-1:0] data_type;

   // Per-cycle command broadcast to every slot cell.
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue slot cell
// One list slot: keeps, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
   parameter int PRIORITY_BITS = 8
) (
   input  wire                       clock,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire                       valid,
   input  wire spq_pkg::data_type    new_data,
   input  wire [PRIORITY_BITS-1:0]   new_prio,
   input  wire                       left_gt,
   input  wire spq_pkg::data_type    left_data,
   input  wire [PRIORITY_BITS-1:0]   left_prio,
   input  wire spq_pkg::data_type    right_data,
   input  wire [PRIORITY_BITS-1:0]   right_prio,
   output spq_pkg::data_type         slot_data,
   output logic [PRIORITY_BITS-1:0]  slot_prio,
   output logic                      gt
);

   spq_pkg::data_type         slot_data_ff, slot_data_in;
   logic [PRIORITY_BITS-1:0]  slot_prio_ff, slot_prio_in;

   // Strictly higher priority than the incoming request: it stays ahead.
   assign gt = valid && (slot_prio_ff > new_prio);

   always_comb begin
      slot_data_in = slot_data_ff;
      slot_prio_in = slot_prio_ff;
      if (ctrl.insert) begin
         if (!gt) begin
            if (left_gt) begin
               slot_data_in = new_data;
               slot_prio_in = new_prio;
            end else begin
               slot_data_in = left_data;
               slot_prio_in = left_prio;
            end
         end
      end else if (ctrl.remove) begin
         slot_data_in = right_data;
         slot_prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      slot_data_ff <= slot_data_in;
      slot_prio_ff <= slot_prio_in;
   end

   assign slot_data = slot_data_ff;
   assign slot_prio = slot_prio_ff;

endmodule

`default_nettype wire

// File: sv/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded queue held as a row of slot cells in descending priority order.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_operation, req_data_in and req_priority_in; the
//   request is taken at a clock edge where busy is low. busy stays low, so a
//   request may be issued in every cycle.
//   Enqueue inserts behind all entries of strictly higher priority and in
//   front of entries of equal priority, so among equal priorities the newest
//   leaves first. Dequeue returns and drops the head, peek returns the head
//   and keeps it.
//   The answer appears in the cycle after the request, for one cycle only, with
//   rsp_valid high: rsp_data_out, rsp_status (ok, empty, full) and
//   rsp_occupancy, the entry count after the request.
//   One request per cycle: every slot cell compares
//   its priority with the request and shifts toward its neighbor at once.
//   The receiver cannot stall; each answer must be taken when shown.
//   Reset empties the queue at once; slot contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_core #(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [spq_pkg::OP_BITS-1:0]        req_operation,
   input  wire  signed [spq_pkg::DATA_BITS-1:0] req_data_in,
   input  wire  [spq_pkg::PRIO_IN_BITS-1:0]   req_priority_in,
   output logic                               rsp_valid,
   output logic signed [spq_pkg::DATA_BITS-1:0] rsp_data_out,
   output logic [spq_pkg::STAT_BITS-1:0]      rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_occupancy
);

   `include "sorted_priority_queue_core_assert.svh"

   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int KEEP_BITS = (PRIORITY_BITS < spq_pkg::PRIO_IN_BITS) ?
                              PRIORITY_BITS : spq_pkg::PRIO_IN_BITS;

   typedef logic [PRIORITY_BITS-1:0] prio_type;
   typedef logic [CNT_BITS-1:0]      count_type;

   count_type               count_ff, count_in;
   logic                    rsp_valid_ff;
   spq_pkg::data_type       rsp_data_ff, rsp_data_in;
   spq_pkg::status_type     rsp_status_ff, rsp_status_in;
   count_type               rsp_occ_ff;

   spq_pkg::cell_ctrl_type  ctrl;
   prio_type                new_prio;
   logic                    accept;
   logic                    full;
   logic                    empty;

   spq_pkg::data_type       slot_data [DEPTH];
   prio_type                slot_prio [DEPTH];
   logic                    slot_gt   [DEPTH];

   logic                    rsp_full;
   logic                    occ_at_depth;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign full     = (count_ff == count_type'(DEPTH));
   assign empty    = (count_ff == '0);
   assign new_prio = prio_type'(req_priority_in[KEEP_BITS-1:0]);

   // Decode the request into cell commands, the next count and the answer.
   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      rsp_data_in   = '0;
      rsp_status_in = spq_pkg::ST_OK;
      if (accept) begin
         case (spq_pkg::op_type'(req_operation))
            spq_pkg::OP_ENQUEUE: begin
               if (full) begin
                  rsp_status_in = spq_pkg::ST_FULL;
               end else begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + count_type'(1);
               end
            end
            spq_pkg::OP_DEQUEUE: begin
               if (empty) begin
                  rsp_status_in = spq_pkg::ST_EMPTY;
               end else begin
                  ctrl.remove = 1'b1;
                  rsp_data_in = slot_data[0];
                  count_in    = count_ff - count_type'(1);
               end
            end
            spq_pkg::OP_PEEK: begin
               if (empty) begin
                  rsp_status_in = spq_pkg::ST_EMPTY;
               end else begin
                  rsp_data_in = slot_data[0];
               end
            end
            default: begin
               rsp_status_in = spq_pkg::ST_OK;
            end
         endcase
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_slot
         spq_pkg::data_type left_data, right_data;
         prio_type          left_prio, right_prio;
         logic              left_gt;

         if (gi == 0) begin : g_head
            assign left_data = req_data_in;
            assign left_prio = new_prio;
            assign left_gt   = 1'b1;
         end else begin : g_body
            assign left_data = slot_data[gi-1];
            assign left_prio = slot_prio[gi-1];
            assign left_gt   = slot_gt[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_tail
            assign right_data = slot_data[gi];
            assign right_prio = slot_prio[gi];
         end else begin : g_next
            assign right_data = slot_data[gi+1];
            assign right_prio = slot_prio[gi+1];
         end

         spq_cell #(
            .PRIORITY_BITS(PRIORITY_BITS)
         ) u_slot (
            .clock      (clock),
            .ctrl       (ctrl),
            .valid      (count_type'(gi) < count_ff),
            .new_data   (req_data_in),
            .new_prio   (new_prio),
            .left_gt    (left_gt),
            .left_data  (left_data),
            .left_prio  (left_prio),
            .right_data (right_data),
            .right_prio (right_prio),
            .slot_data  (slot_data[gi]),
            .slot_prio  (slot_prio[gi]),
            .gt         (slot_gt[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // Checks

   assign rsp_full     = rsp_valid_ff && (rsp_status_ff == spq_pkg::ST_FULL);
   assign occ_at_depth = (rsp_occ_ff == count_type'(DEPTH));

   `SPQ_ASSERT_NEXT(a_rsp_follows_req, accept, rsp_valid_ff, "request got no response")

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= count_type'(DEPTH), "count beyond depth")

   `SPQ_ASSERT_NOW(a_full_occ, rsp_full, occ_at_depth, "full status with room left")

   generate
      for (gi = 0; gi < DEPTH - 1; gi++) begin : g_order_chk
         logic pair_live;
         logic pair_sorted;
         assign pair_live   = (count_type'(gi + 1) < count_ff);
         assign pair_sorted = (slot_prio[gi] >= slot_prio[gi+1]);
         `SPQ_ASSERT_NOW(a_sorted, pair_live, pair_sorted, "slots out of priority order")
      end
   endgenerate

endmodule

`default_nettype wire
